[sv/ncm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_pkg
// shared widths, codes and the metadata beat type for the normalization cube map
// ----------------------------------------------------------------------------
package ncm_pkg;

    localparam int CUBE_W            = 11;
    localparam int COORD_W           = 10;
    localparam int FACE_W            = 3;
    localparam int BYTE_W            = 8;
    localparam int INDEX_W           = 20;
    localparam int K_W               = 7;
    localparam int LANES             = 3;
    localparam int MAX_FACE_SIZE_DEF = 1024;
    localparam int ENC_SCALE         = 16129;
    localparam logic [CUBE_W-1:0] CUBE_SIZE_RESET = 11'd256;
    localparam logic [BYTE_W-1:0] ENC_MID         = 8'd128;
    localparam logic [K_W-1:0]    K_MAX           = 7'd127;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               bad;
    } meta_t;

endpackage

[sv/ncm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_front
// three stage prep: face vector, squares, scaled targets for the search cells
// ----------------------------------------------------------------------------
module ncm_front #(
    parameter int MAX_FACE_SIZE = ncm_pkg::MAX_FACE_SIZE_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [ncm_pkg::CUBE_W-1:0]             cube_size,
    input  logic                                   up_valid,
    output logic                                   up_ready,
    input  logic [ncm_pkg::FACE_W-1:0]             face,
    input  logic [ncm_pkg::COORD_W-1:0]            column,
    input  logic [ncm_pkg::COORD_W-1:0]            row,
    output logic                                   dn_valid,
    input  logic                                   dn_ready,
    output logic [2*$clog2(MAX_FACE_SIZE+1)+1:0]   dn_s,
    output logic [2*$clog2(MAX_FACE_SIZE+1)+13:0]  dn_t [ncm_pkg::LANES],
    output logic                                   dn_neg [ncm_pkg::LANES],
    output ncm_pkg::meta_t                         dn_meta
);
    import ncm_pkg::*;

    localparam int NW = $clog2(MAX_FACE_SIZE + 1);
    localparam int AW = NW + 1;
    localparam int EW = ((NW > CUBE_W) ? NW : CUBE_W) + 2;
    localparam int XW = ((CUBE_W + NW) > INDEX_W) ? (CUBE_W + NW) : INDEX_W;
    localparam int SW = 2 * NW + 2;
    localparam int TW = 2 * NW + 14;

    // stage 1 comb
    logic [NW-1:0]          n_c;
    logic                   bad_c;
    logic signed [EW-1:0]   a_w;
    logic signed [EW-1:0]   b_w;
    logic signed [AW-1:0]   a_c;
    logic signed [AW-1:0]   b_c;
    logic signed [AW-1:0]   nn_c;
    logic [XW-1:0]          idx_w;
    logic signed [AW-1:0]   vec_c [LANES];

    always_comb
    begin
        n_c   = (int'(cube_size) > MAX_FACE_SIZE) ? NW'(MAX_FACE_SIZE) : NW'(cube_size);
        bad_c = (EW'(column) >= EW'(n_c)) || (EW'(row) >= EW'(n_c));
        a_w   = $signed(EW'({column, 1'b1})) - $signed(EW'(n_c));
        b_w   = $signed(EW'({row, 1'b1})) - $signed(EW'(n_c));
        a_c   = a_w[AW-1:0];
        b_c   = b_w[AW-1:0];
        nn_c  = $signed({1'b0, n_c});
        idx_w = XW'(row) * XW'(n_c) + XW'(column);
        unique case (face)
            FACE_POS_X:
            begin
                vec_c[0] = nn_c;  vec_c[1] = -b_c;  vec_c[2] = -a_c;
            end
            FACE_NEG_X:
            begin
                vec_c[0] = -nn_c; vec_c[1] = -b_c;  vec_c[2] = a_c;
            end
            FACE_POS_Y:
            begin
                vec_c[0] = a_c;   vec_c[1] = nn_c;  vec_c[2] = b_c;
            end
            FACE_NEG_Y:
            begin
                vec_c[0] = a_c;   vec_c[1] = -nn_c; vec_c[2] = -b_c;
            end
            FACE_POS_Z:
            begin
                vec_c[0] = a_c;   vec_c[1] = -b_c;  vec_c[2] = nn_c;
            end
            FACE_NEG_Z:
            begin
                vec_c[0] = -a_c;  vec_c[1] = -b_c;  vec_c[2] = -nn_c;
            end
            default:
            begin
                vec_c[0] = '0;    vec_c[1] = '0;    vec_c[2] = '0;
            end
        endcase
    end

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 r1, r2, r3;
    logic signed [AW-1:0] a1_reg, b1_reg;
    logic [NW-1:0]        n1_reg;
    logic signed [AW-1:0] vec1_reg [LANES];
    meta_t                meta1_reg, meta2_reg, meta3_reg;

    assign r3       = !v3_reg || dn_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign up_ready = r1;

    // stage 2 comb: magnitudes and squares
    logic [NW-1:0]   ma, mb;
    logic [NW-1:0]   mv [LANES];
    logic [SW-1:0]   s_next;
    logic [2*NW-1:0] msq_next [LANES];
    logic [AW-1:0]   neg_a, neg_b;
    logic [AW-1:0]   neg_v [LANES];

    always_comb
    begin
        neg_a  = -a1_reg;
        neg_b  = -b1_reg;
        ma     = a1_reg[AW-1] ? neg_a[NW-1:0] : a1_reg[NW-1:0];
        mb     = b1_reg[AW-1] ? neg_b[NW-1:0] : b1_reg[NW-1:0];
        s_next = SW'(ma) * SW'(ma) + SW'(mb) * SW'(mb) + SW'(n1_reg) * SW'(n1_reg);
        for (int l = 0; l < LANES; l++)
        begin
            neg_v[l]    = -vec1_reg[l];
            mv[l]       = vec1_reg[l][AW-1] ? neg_v[l][NW-1:0] : vec1_reg[l][NW-1:0];
            msq_next[l] = mv[l] * mv[l];
        end
    end

    logic [SW-1:0]   s2_reg;
    logic [2*NW-1:0] msq2_reg [LANES];
    logic            neg2_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= up_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            a1_reg          <= a_c;
            b1_reg          <= b_c;
            n1_reg          <= n_c;
            vec1_reg        <= vec_c;
            meta1_reg.index <= idx_w[INDEX_W-1:0];
            meta1_reg.bad   <= bad_c;
        end
        if (r2 && v1_reg)
        begin
            s2_reg    <= s_next;
            msq2_reg  <= msq_next;
            meta2_reg <= meta1_reg;
            for (int l = 0; l < LANES; l++)
                neg2_reg[l] <= vec1_reg[l][AW-1];
        end
        if (r3 && v2_reg)
        begin
            dn_s      <= s2_reg;
            meta3_reg <= meta2_reg;
            for (int l = 0; l < LANES; l++)
            begin
                dn_t[l]   <= TW'(msq2_reg[l]) * TW'(ENC_SCALE);
                dn_neg[l] <= neg2_reg[l];
            end
        end
    end

    assign dn_valid = v3_reg;
    assign dn_meta  = meta3_reg;

endmodule

[sv/ncm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_cell
// one search cell: settles one bit of the encoded magnitude for all three lanes
// ----------------------------------------------------------------------------
module ncm_cell #(
    parameter int BIT = 0,
    parameter int SW  = 24,
    parameter int TW  = 36
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic [SW-1:0]             up_s,
    input  logic [TW-1:0]             up_t   [ncm_pkg::LANES],
    input  logic                      up_neg [ncm_pkg::LANES],
    input  logic [ncm_pkg::K_W-1:0]   up_k   [ncm_pkg::LANES],
    input  logic [SW+15:0]            up_q   [ncm_pkg::LANES],
    input  logic [SW+15:0]            up_r   [ncm_pkg::LANES],
    input  ncm_pkg::meta_t            up_meta,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic [SW-1:0]             dn_s,
    output logic [TW-1:0]             dn_t   [ncm_pkg::LANES],
    output logic                      dn_neg [ncm_pkg::LANES],
    output logic [ncm_pkg::K_W-1:0]   dn_k   [ncm_pkg::LANES],
    output logic [SW+15:0]            dn_q   [ncm_pkg::LANES],
    output logic [SW+15:0]            dn_r   [ncm_pkg::LANES],
    output ncm_pkg::meta_t            dn_meta
);
    import ncm_pkg::*;

    localparam int PW = SW + 16;

    // q holds k*k*s and r holds k*s, so trying k + 2^BIT needs only shifts and adds
    logic [PW-1:0]  cand_q [LANES];
    logic [PW-1:0]  cand_r [LANES];
    logic           take   [LANES];
    logic [K_W-1:0] k_next [LANES];
    logic [PW-1:0]  q_next [LANES];
    logic [PW-1:0]  r_next [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            cand_q[l] = up_q[l] + (up_r[l] << (BIT + 1)) + (PW'(up_s) << (2 * BIT));
            cand_r[l] = up_r[l] + (PW'(up_s) << BIT);
            take[l]   = up_neg[l] ? (cand_q[l] < PW'(up_t[l])) : (cand_q[l] <= PW'(up_t[l]));
            k_next[l] = take[l] ? (up_k[l] | K_W'(1 << BIT)) : up_k[l];
            q_next[l] = take[l] ? cand_q[l] : up_q[l];
            r_next[l] = take[l] ? cand_r[l] : up_r[l];
        end
    end

    logic valid_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            dn_s    <= up_s;
            dn_t    <= up_t;
            dn_neg  <= up_neg;
            dn_k    <= k_next;
            dn_q    <= q_next;
            dn_r    <= r_next;
            dn_meta <= up_meta;
        end
    end

endmodule

[sv/ncm_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_out
// output register: turns search results into bytes, blanks bad coordinates
// ----------------------------------------------------------------------------
module ncm_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [ncm_pkg::K_W-1:0]       up_k   [ncm_pkg::LANES],
    input  logic                          up_neg [ncm_pkg::LANES],
    input  ncm_pkg::meta_t                up_meta,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ncm_pkg::BYTE_W-1:0]    byte_q [ncm_pkg::LANES],
    output logic [ncm_pkg::INDEX_W-1:0]   index_q,
    output logic                          bad_q
);
    import ncm_pkg::*;

    logic [K_W-1:0]    kk   [LANES];
    logic [BYTE_W-1:0] enc  [LANES];
    logic              valid_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            // negative side: smallest k with k*k*s >= target is the search result plus one
            kk[l] = (up_k[l] == K_MAX) ? K_MAX : (up_k[l] + K_W'(1));
            if (up_meta.bad)
                enc[l] = '0;
            else if (up_neg[l])
                enc[l] = ENC_MID - BYTE_W'(kk[l]);
            else
                enc[l] = ENC_MID + BYTE_W'(up_k[l]);
        end
    end

    assign up_ready  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            byte_q  <= enc;
            index_q <= up_meta.bad ? '0 : up_meta.index;
            bad_q   <= up_meta.bad;
        end
    end

endmodule

[sv/normalization_cube_map_texel_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalization_cube_map_texel_top
// pipeline: 3 prep stages, 7 search cells, 1 output register
// throughput: one texel per cycle while out_stall is low, every stage holds its own beat
// the seven cells each settle one bit of the 7-bit magnitude search per lane
// reset: pipeline empty, cube_size back to 256
// ----------------------------------------------------------------------------
module normalization_cube_map_texel_top #(
    parameter int MAX_FACE_SIZE = ncm_pkg::MAX_FACE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_write,
    input  logic [ncm_pkg::CUBE_W-1:0]    cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ncm_pkg::FACE_W-1:0]    face,
    input  logic [ncm_pkg::COORD_W-1:0]   column,
    input  logic [ncm_pkg::COORD_W-1:0]   row,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ncm_pkg::BYTE_W-1:0]    red,
    output logic [ncm_pkg::BYTE_W-1:0]    green,
    output logic [ncm_pkg::BYTE_W-1:0]    blue,
    output logic [ncm_pkg::INDEX_W-1:0]   texel_index,
    output logic                          bad_coordinate
);
    import ncm_pkg::*;

    localparam int NW = $clog2(MAX_FACE_SIZE + 1);
    localparam int SW = 2 * NW + 2;
    localparam int TW = 2 * NW + 14;
    localparam int PW = SW + 16;

    // cube size register; the user must write it only while the pipe is idle, the block does not enforce it
    logic [CUBE_W-1:0] cube_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cube_size_reg <= CUBE_SIZE_RESET;
        else if (cfg_write)
            cube_size_reg <= cfg_data;
    end

    // chain links: index 0 is the front output, index K_W the last cell output
    logic           c_valid [K_W+1];
    logic           c_ready [K_W+1];
    logic [SW-1:0]  c_s     [K_W+1];
    logic [TW-1:0]  c_t     [K_W+1][LANES];
    logic           c_neg   [K_W+1][LANES];
    logic [K_W-1:0] c_k     [K_W+1][LANES];
    logic [PW-1:0]  c_q     [K_W+1][LANES];
    logic [PW-1:0]  c_r     [K_W+1][LANES];
    meta_t          c_meta  [K_W+1];
    logic           in_ready;

    assign in_stall = !in_ready;

    // face vector, squared norm and scaled targets
    ncm_front #(
        .MAX_FACE_SIZE (MAX_FACE_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cube_size (cube_size_reg),
        .up_valid  (in_valid),
        .up_ready  (in_ready),
        .face      (face),
        .column    (column),
        .row       (row),
        .dn_valid  (c_valid[0]),
        .dn_ready  (c_ready[0]),
        .dn_s      (c_s[0]),
        .dn_t      (c_t[0]),
        .dn_neg    (c_neg[0]),
        .dn_meta   (c_meta[0])
    );

    // the search starts from k = 0 in every lane
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            c_k[0][l] = '0;
            c_q[0][l] = '0;
            c_r[0][l] = '0;
        end
    end

    // msb first: cell g settles bit K_W-1-g
    for (genvar g = 0; g < K_W; g++)
    begin : g_cell
        ncm_cell #(
            .BIT (K_W - 1 - g),
            .SW  (SW),
            .TW  (TW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_valid[g]),
            .up_ready (c_ready[g]),
            .up_s     (c_s[g]),
            .up_t     (c_t[g]),
            .up_neg   (c_neg[g]),
            .up_k     (c_k[g]),
            .up_q     (c_q[g]),
            .up_r     (c_r[g]),
            .up_meta  (c_meta[g]),
            .dn_valid (c_valid[g+1]),
            .dn_ready (c_ready[g+1]),
            .dn_s     (c_s[g+1]),
            .dn_t     (c_t[g+1]),
            .dn_neg   (c_neg[g+1]),
            .dn_k     (c_k[g+1]),
            .dn_q     (c_q[g+1]),
            .dn_r     (c_r[g+1]),
            .dn_meta  (c_meta[g+1])
        );
    end

    // output register, parts the pipe from a stalled consumer
    logic [BYTE_W-1:0] bytes [LANES];

    ncm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (c_valid[K_W]),
        .up_ready  (c_ready[K_W]),
        .up_k      (c_k[K_W]),
        .up_neg    (c_neg[K_W]),
        .up_meta   (c_meta[K_W]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .byte_q    (bytes),
        .index_q   (texel_index),
        .bad_q     (bad_coordinate)
    );

    assign red   = bytes[0];
    assign green = bytes[1];
    assign blue  = bytes[2];

endmodule
